// ===== hw/rtl/tlv_pkg.sv =====
// package for the tlv metadata parser: word types and result codes
`timescale 1ns / 1ps
`default_nettype none

package tlv_pkg;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_VERSION   = 2'd1,
      ERR_PREMATURE = 2'd2
   } error_code_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      kind_type       kind;
      logic [7:0]     entry_type;
      logic [7:0]     value_byte;
      logic [15:0]    value_index;
      logic           entry_end;
      error_code_type error_code;
   } rsp_word_type;

   localparam logic [7:0] EXPECTED_VERSION_RESET = 8'd1;

endpackage

`default_nettype wire

// ===== hw/rtl/tlv_metadata_parser.sv =====
// top level of the tlv metadata parser
`timescale 1ns / 1ps
`default_nettype none

// tlv metadata parser
// - req channel: one byte of a metadata block per word, last_byte marks the
//   final byte; the first byte is a version checked against the csr register
// - after the version come entries: type byte, big-endian 16-bit length,
//   then that many value bytes
// - rsp channel: one word per value byte (type, index, end mark), one word
//   per empty entry, one error word on version mismatch or a block that ends
//   inside an entry; bytes after a version error are dropped silently
// - csr channel: writes expected_version, always ready; write only while idle
// - each result word is registered into the output reg, or into the skid reg when a result already waits
// - throughput: one byte per cycle while req_ready is high; the parse step is a single phase update
//   plus a 16-bit decrement and increment between the byte and the result reg
// - a two-entry result queue (output reg plus skid reg) sits on rsp, so bytes
//   keep flowing while one result waits; req_ready drops only when both are
//   full, i.e. from the cycle after a new result meets a stalled output reg
// - reset: phase back to expecting a version byte, expected_version back to
//   1, result queue empty
module tlv_metadata_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire tlv_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output tlv_pkg::rsp_word_type rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [7:0]             csr_data
);
   import tlv_pkg::*;

   // parse phase, one-hot
   typedef enum logic [5:0] {
      PH_VERSION = 6'b000001,
      PH_TYPE    = 6'b000010,
      PH_LEN_HI  = 6'b000100,
      PH_LEN_LO  = 6'b001000,
      PH_VALUE   = 6'b010000,
      PH_DROP    = 6'b100000
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [7:0]   cur_type_ff, cur_type_in;
   logic [7:0]   len_hi_ff, len_hi_in;
   logic [15:0]  bytes_left_ff, bytes_left_in;
   logic [15:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]   exp_version_ff;

   // result queue: output reg and skid reg
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   logic         req_take;
   logic         rsp_take;
   logic         res_valid;
   rsp_word_type res_word;
   logic         new_res;
   logic [15:0]  entry_len;
   logic         value_end;

   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;
   assign rsp_take  = out_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   assign entry_len = {len_hi_ff, req_data.data_byte};
   assign value_end = (bytes_left_ff <= 16'd1);

   // one parse step for the byte on req_data
   always_comb begin
      phase_in      = phase_ff;
      cur_type_in   = cur_type_ff;
      len_hi_in     = len_hi_ff;
      bytes_left_in = bytes_left_ff;
      byte_pos_in   = byte_pos_ff;
      res_valid     = 1'b0;
      res_word      = '{kind: KIND_ERROR, entry_type: cur_type_ff, value_byte: 8'd0,
                        value_index: 16'd0, entry_end: 1'b0, error_code: ERR_PREMATURE};
      unique case (phase_ff)
         PH_VERSION: begin
            if (req_data.data_byte != exp_version_ff) begin
               res_valid           = 1'b1;
               res_word.entry_type = 8'd0;
               res_word.error_code = ERR_VERSION;
               phase_in = req_data.last_byte ? PH_VERSION : PH_DROP;
            end else begin
               phase_in = req_data.last_byte ? PH_VERSION : PH_TYPE;
            end
         end
         PH_TYPE: begin
            cur_type_in         = req_data.data_byte;
            res_word.entry_type = req_data.data_byte;
            if (req_data.last_byte) begin
               res_valid = 1'b1;
               phase_in  = PH_VERSION;
            end else begin
               phase_in  = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            len_hi_in = req_data.data_byte;
            if (req_data.last_byte) begin
               res_valid = 1'b1;
               phase_in  = PH_VERSION;
            end else begin
               phase_in  = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            if (entry_len == 16'd0) begin
               // empty entry
               res_valid           = 1'b1;
               res_word.kind       = KIND_EMPTY;
               res_word.entry_end  = 1'b1;
               res_word.error_code = ERR_NONE;
               phase_in = req_data.last_byte ? PH_VERSION : PH_TYPE;
            end else if (req_data.last_byte) begin
               res_valid = 1'b1;
               phase_in  = PH_VERSION;
            end else begin
               bytes_left_in = entry_len;
               byte_pos_in   = 16'd0;
               phase_in      = PH_VALUE;
            end
         end
         PH_VALUE: begin
            res_valid            = 1'b1;
            res_word.value_index = byte_pos_ff;
            if (req_data.last_byte && !value_end) begin
               // block ends inside the value, byte replaced by error
               phase_in = PH_VERSION;
            end else begin
               res_word.kind       = KIND_VALUE;
               res_word.value_byte = req_data.data_byte;
               res_word.entry_end  = value_end;
               res_word.error_code = ERR_NONE;
               byte_pos_in         = byte_pos_ff + 16'd1;
               if (value_end) begin
                  bytes_left_in = 16'd0;
                  phase_in = req_data.last_byte ? PH_VERSION : PH_TYPE;
               end else begin
                  bytes_left_in = bytes_left_ff - 16'd1;
               end
            end
         end
         default: begin
            // drop phase: skip to end of block
            phase_in = req_data.last_byte ? PH_VERSION : PH_DROP;
         end
      endcase
   end

   assign new_res = req_take && res_valid;

   // result queue steering
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = new_res;
            skid_word_in  = res_word;
         end else begin
            out_valid_in  = new_res;
            out_word_in   = res_word;
         end
      end else if (new_res) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_VERSION;
         cur_type_ff    <= 8'd0;
         len_hi_ff      <= 8'd0;
         bytes_left_ff  <= 16'd0;
         byte_pos_ff    <= 16'd0;
         exp_version_ff <= EXPECTED_VERSION_RESET;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff      <= phase_in;
            cur_type_ff   <= cur_type_in;
            len_hi_ff     <= len_hi_in;
            bytes_left_ff <= bytes_left_in;
            byte_pos_ff   <= byte_pos_in;
         end
         if (csr_valid && csr_ready) begin
            exp_version_ff <= csr_data;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   // skid entry only ever sits behind a full output reg
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid reg valid with empty output reg");

   // inside a value there is always at least one byte to come
   a_value_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> (bytes_left_ff != 16'd0))
      else $error("value phase with no bytes left");

   // an error result always ends the entry: next phase is version or drop
   a_error_resync: assert property (@(posedge clock) disable iff (reset)
      (new_res && res_word.kind == KIND_ERROR) |=>
         (phase_ff == PH_VERSION || phase_ff == PH_DROP))
      else $error("parser not resynced after error");

   // a result accepted while both queue slots are busy would be lost
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_take) |-> !new_res)
      else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== dv/tlv_metadata_checker.sv =====
// checker for the tlv metadata parser: predicts result words and compares them
`timescale 1ns / 1ps

module tlv_metadata_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  tlv_pkg::req_word_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tlv_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [7:0]            csr_data,
   output int                    fail_count,
   output int                    words_pending,
   output int                    words_checked
);
   import tlv_pkg::*;

   typedef enum logic [2:0] {
      AWAIT_VERSION,
      AWAIT_TYPE,
      AWAIT_LEN_HI,
      AWAIT_LEN_LO,
      IN_VALUE,
      DISCARD
   } parse_phase_type;

   parse_phase_type phase_q;
   logic [7:0]    version_q;
   logic [7:0]    type_q;
   logic [7:0]    len_hi_q;
   logic [15:0]   left_q;
   logic [15:0]   pos_q;
   rsp_word_type  expected_words [$];

   // advance the parse state by one byte, queue the word it should produce
   task automatic parse_byte(input req_word_type w);
      rsp_word_type r;
      logic [15:0]  len;
      logic         produces;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = ERR_NONE;
      produces = 1'b0;
      len = {len_hi_q, w.data_byte};
      case (phase_q)
         AWAIT_VERSION: begin
            if (w.data_byte != version_q) begin
               r.error_code = ERR_VERSION;
               produces = 1'b1;
               phase_q = w.last_byte ? AWAIT_VERSION : DISCARD;
            end else begin
               phase_q = w.last_byte ? AWAIT_VERSION : AWAIT_TYPE;
            end
         end
         AWAIT_TYPE: begin
            type_q = w.data_byte;
            if (w.last_byte) begin
               r.entry_type = type_q;
               r.error_code = ERR_PREMATURE;
               produces = 1'b1;
               phase_q = AWAIT_VERSION;
            end else begin
               phase_q = AWAIT_LEN_HI;
            end
         end
         AWAIT_LEN_HI: begin
            len_hi_q = w.data_byte;
            if (w.last_byte) begin
               r.entry_type = type_q;
               r.error_code = ERR_PREMATURE;
               produces = 1'b1;
               phase_q = AWAIT_VERSION;
            end else begin
               phase_q = AWAIT_LEN_LO;
            end
         end
         AWAIT_LEN_LO: begin
            r.entry_type = type_q;
            produces = 1'b1;
            if (len == 16'd0) begin
               r.kind = KIND_EMPTY;
               r.entry_end = 1'b1;
               phase_q = w.last_byte ? AWAIT_VERSION : AWAIT_TYPE;
            end else if (w.last_byte) begin
               r.error_code = ERR_PREMATURE;
               phase_q = AWAIT_VERSION;
            end else begin
               produces = 1'b0;
               left_q = len;
               pos_q = 16'd0;
               phase_q = IN_VALUE;
            end
         end
         IN_VALUE: begin
            r.entry_type = type_q;
            r.value_index = pos_q;
            produces = 1'b1;
            if (w.last_byte && left_q > 16'd1) begin
               // block ends short: the byte is replaced by an error word
               r.error_code = ERR_PREMATURE;
               phase_q = AWAIT_VERSION;
            end else begin
               r.kind = KIND_VALUE;
               r.value_byte = w.data_byte;
               r.entry_end = (left_q <= 16'd1);
               left_q = left_q - 16'd1;
               pos_q = pos_q + 16'd1;
               if (r.entry_end) begin
                  left_q = 16'd0;
                  phase_q = w.last_byte ? AWAIT_VERSION : AWAIT_TYPE;
               end
            end
         end
         default: begin
            phase_q = w.last_byte ? AWAIT_VERSION : DISCARD;
         end
      endcase
      if (produces)
         expected_words.insert(expected_words.size(), r);
   endtask

   task automatic compare_word(input rsp_word_type got);
      rsp_word_type exp;
      int           bad;
      bad = 0;
      if (expected_words.size() == 0) begin
         $error("result word arrived with nothing expected");
         fail_count++;
         return;
      end
      exp = expected_words.pop_front();
      if (got.kind != exp.kind) begin
         $error("kind: expected %0d, got %0d", exp.kind, got.kind);
         bad++;
      end
      if (got.entry_type != exp.entry_type) begin
         $error("entry_type: expected %0h, got %0h", exp.entry_type, got.entry_type);
         bad++;
      end
      if (got.value_byte != exp.value_byte) begin
         $error("value_byte: expected %0h, got %0h", exp.value_byte, got.value_byte);
         bad++;
      end
      if (got.value_index != exp.value_index) begin
         $error("value_index: expected %0d, got %0d", exp.value_index, got.value_index);
         bad++;
      end
      if (got.entry_end != exp.entry_end) begin
         $error("entry_end: expected %0b, got %0b", exp.entry_end, got.entry_end);
         bad++;
      end
      if (got.error_code != exp.error_code) begin
         $error("error_code: expected %0d, got %0d", exp.error_code, got.error_code);
         bad++;
      end
      if (bad != 0)
         fail_count++;
      words_checked++;
   endtask

   // outgoing word is compared before the incoming byte is predicted,
   // a result never belongs to the byte accepted on the same edge
   always @(posedge clock) begin
      if (reset) begin
         phase_q = AWAIT_VERSION;
         version_q = EXPECTED_VERSION_RESET;
         type_q = 8'd0;
         len_hi_q = 8'd0;
         left_q = 16'd0;
         pos_q = 16'd0;
         expected_words.delete();
         fail_count = 0;
         words_checked = 0;
      end else begin
         if (csr_valid && csr_ready)
            version_q = csr_data;
         if (rsp_valid && rsp_ready)
            compare_word(rsp_data);
         if (req_valid && req_ready)
            parse_byte(req_data);
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== dv/tb.sv =====
// testbench top for the tlv metadata parser: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
   import tlv_pkg::*;

   typedef logic [7:0] byte_list_type [$];

   // cycles without any accepted word before the run is declared hung
   localparam int HANG_LIMIT = 3000;
   // bytes per version setting in the random part
   localparam int PHASE_BYTES = 160;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;

   int           fail_count;
   int           words_pending;
   int           words_checked;
   int           idle_cycles;
   int           bytes_sent;
   int           blocks_sent;
   int           rsp_stall_left;
   logic         steady;        // when set neither side idles
   logic [7:0]   version_now;   // version the block currently expects

   tlv_metadata_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   tlv_metadata_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: none while steady, else mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // value length: short entries dominate, empty ones are common
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 4);
      if (r < 95)
         return $urandom_range(5, 16);
      return $urandom_range(17, 300);
   endfunction

   // consumer side: stretches of ready broken by stalls of random length
   initial begin
      rsp_ready = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
               rsp_stall_left = pick_gap();
         end
      end
   end

   // hang detection: any accepted word on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one byte on req; called at a falling edge, returns at the falling edge
   // after acceptance with valid still high, so the caller either drops it
   // or puts the next byte on the same edge
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{data_byte: value, last_byte: is_last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_block(input byte_list_type blk);
      for (int i = 0; i < blk.size(); i++)
         send_byte(blk[i], i == blk.size() - 1);
      blocks_sent++;
   endtask

   // register writes only with the parser drained and quiet
   task automatic write_version(input logic [7:0] value);
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      version_now = value;
   endtask

   // one well-formed entry appended to a block
   task automatic add_entry(inout byte_list_type blk);
      int len;
      len = pick_length();
      blk.insert(blk.size(), 8'($urandom_range(0, 255)));
      blk.insert(blk.size(), len[15:8]);
      blk.insert(blk.size(), len[7:0]);
      repeat (len) blk.insert(blk.size(), 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_block();
      byte_list_type blk;
      int         r;
      int         len;
      int         keep;
      r = $urandom_range(0, 99);
      blk = {};
      if (r < 70) begin
         // well-formed, possibly version only
         blk.insert(blk.size(), version_now);
         repeat ($urandom_range(0, 4)) add_entry(blk);
      end else if (r < 85) begin
         // well-formed prefix, then an entry cut short in type, length or value
         blk.insert(blk.size(), version_now);
         repeat ($urandom_range(0, 2)) add_entry(blk);
         len = $urandom_range(1, 65535);
         keep = $urandom_range(1, 3 + ((len - 1 < 4) ? len - 1 : 4));
         blk.insert(blk.size(), 8'($urandom_range(0, 255)));
         if (keep >= 2)
            blk.insert(blk.size(), len[15:8]);
         if (keep >= 3)
            blk.insert(blk.size(), len[7:0]);
         repeat (keep - 3) blk.insert(blk.size(), 8'($urandom_range(0, 255)));
      end else if (r < 93) begin
         // wrong version, the tail is dropped by the parser
         blk.insert(blk.size(), version_now ^ 8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 5)) blk.insert(blk.size(), 8'($urandom_range(0, 255)));
      end else begin
         // raw noise
         repeat ($urandom_range(1, 8)) blk.insert(blk.size(), 8'($urandom_range(0, 255)));
      end
      send_block(blk);
   endtask

   initial begin
      byte_list_type blk;
      logic [7:0]  settings [5];
      int          target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 8'd0;
      steady = 1'b0;
      bytes_sent = 0;
      blocks_sent = 0;
      version_now = EXPECTED_VERSION_RESET;
      settings[0] = 8'h00;
      settings[1] = 8'hFF;
      settings[2] = 8'($urandom_range(0, 255));
      settings[3] = 8'h80;
      settings[4] = 8'h7F;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, version register at its reset value
      // matching version alone ends the block with no word
      blk = {8'h01};
      send_block(blk);
      // mismatching version as the only byte
      blk = {8'h00};
      send_block(blk);
      // mismatching version, remaining bytes dropped
      blk = {8'hFF, 8'h12, 8'h34};
      send_block(blk);
      // one-byte value, then an empty entry that closes the block
      blk = {8'h01, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h00, 8'h00};
      send_block(blk);
      // block ends on the type byte
      blk = {8'h01, 8'h7E};
      send_block(blk);
      // block ends on the high length byte
      blk = {8'h01, 8'h5A, 8'hFF};
      send_block(blk);
      // block ends on a nonzero low length byte
      blk = {8'h01, 8'hA5, 8'h00, 8'h02};
      send_block(blk);
      // block ends inside a long value
      blk = {8'h01, 8'h33, 8'hFF, 8'hFF, 8'hAA, 8'h55};
      send_block(blk);

      // random part: one stretch per register setting, idling on every other
      foreach (settings[p]) begin
         write_version(settings[p]);
         steady = (p % 2 == 1);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target)
            send_random_block();
      end

      req_valid <= 1'b0;
      steady = 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("covered %0d bytes in %0d blocks, %0d result words checked",
               bytes_sent, blocks_sent, words_checked);
      $display("version register taken through reset value and %0d writes",
               $size(settings));
      if (fail_count == 0 && words_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tlv_pkg.sv
hw/rtl/tlv_metadata_parser.sv
dv/tlv_metadata_checker.sv
dv/tb.sv
